FILE: sv/srisu_pkg.sv
// ----------------------------------------------------------------------------
// srisu_pkg: shared types for the stable record insertion sorter
// Record, beat and cell link types, key builder and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package srisu_pkg;

	localparam int unsigned CAPACITY_DEF = 32;
	localparam int unsigned ID_W         = 32;
	localparam int unsigned GENDER_W     = 8;
	localparam int unsigned SCORE_W      = 7;
	localparam int unsigned ARRIVAL_W    = 6;
	localparam int unsigned TOTAL_W      = 9;
	localparam int unsigned KEY_W        = 32;
	localparam int unsigned APB_ADDR_W   = 3;
	localparam int unsigned APB_DATA_W   = 32;

	// key select codes, code three falls back to the score key
	localparam logic [1:0] KEY_ID     = 2'd0;
	localparam logic [1:0] KEY_GENDER = 2'd1;

	// register index as seen on paddr[2]
	localparam logic REG_KEY_SELECT = 1'b0;
	localparam logic REG_DESCENDING = 1'b1;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]      student_id;
		logic [GENDER_W-1:0]  gender_code;
		logic [SCORE_W-1:0]   score_first;
		logic [SCORE_W-1:0]   score_second;
		logic [SCORE_W-1:0]   score_third;
		logic [ARRIVAL_W-1:0] arrival;
	} rec_t;

	typedef struct packed {
		logic [ID_W-1:0]     student_id;
		logic [GENDER_W-1:0] gender_code;
		logic [SCORE_W-1:0]  score_first;
		logic [SCORE_W-1:0]  score_second;
		logic [SCORE_W-1:0]  score_third;
		logic                last_record;
	} in_beat_t;

	typedef struct packed {
		logic [ID_W-1:0]      out_id;
		logic [GENDER_W-1:0]  out_gender;
		logic [SCORE_W-1:0]   out_score_first;
		logic [SCORE_W-1:0]   out_score_second;
		logic [SCORE_W-1:0]   out_score_third;
		logic [ARRIVAL_W-1:0] arrival_index;
		logic                 same_key_as_before;
		logic                 overflow;
		logic                 last_out;
	} out_beat_t;

	// broadcast commands to every cell
	typedef struct packed {
		logic ins;
		logic drain;
	} cell_ctl_t;

	// per-cell insertion status
	typedef struct packed {
		logic occ;
		logic pass;
		logic left_occ;
		logic left_pass;
	} cell_link_t;

	// ascending key, total score key packs total then the tie-break scores
	function automatic logic [KEY_W-1:0] sort_key(input logic [1:0] sel, input rec_t r);
		logic [TOTAL_W-1:0] total;
		total = TOTAL_W'(r.score_first) + TOTAL_W'(r.score_second)
			+ TOTAL_W'(r.score_third);
		unique case (sel)
			KEY_ID:     sort_key = r.student_id;
			KEY_GENDER: sort_key = KEY_W'(r.gender_code);
			default:    sort_key = KEY_W'({total, r.score_first, r.score_second,
				r.score_third});
		endcase
	endfunction

endpackage

`default_nettype wire

FILE: sv/srisu_cell.sv
// ----------------------------------------------------------------------------
// srisu_cell: one slot of the sorted record chain
// Compares its record with the arriving one, shifts right on insert, left on drain.
// ----------------------------------------------------------------------------
`default_nettype none

module srisu_cell (
	input  wire logic                            clk,
	input  wire srisu_pkg::cell_ctl_t            ctl,
	input  wire srisu_pkg::cell_link_t           link,
	input  wire logic [1:0]                      key_select,
	input  wire logic                            descending,
	input  wire srisu_pkg::rec_t                 new_rec,
	input  wire logic [srisu_pkg::KEY_W-1:0]     new_key,
	input  wire srisu_pkg::rec_t                 left_rec,
	input  wire srisu_pkg::rec_t                 right_rec,
	output srisu_pkg::rec_t                      rec_q,
	output logic                                 le
);

	logic [srisu_pkg::KEY_W-1:0] key;
	logic                        gt;
	logic                        we_ins;

	always_comb begin
		key    = srisu_pkg::sort_key(key_select, rec_q);
		gt     = descending ? (key < new_key) : (key > new_key);
		le     = link.occ & ~gt;
		we_ins = ctl.ins & link.pass & (link.occ | link.left_occ);
	end

	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			rec_q <= right_rec;
		end else if (we_ins) begin
			rec_q <= link.left_pass ? left_rec : new_rec;
		end
	end

endmodule

`default_nettype wire

FILE: sv/stable_record_insertion_sorter_unit.sv
// ----------------------------------------------------------------------------
// stable_record_insertion_sorter_unit: record sorter built on a cell chain
// The last record beat switches the sequencer to the drain state, which loads
//   the first result beat once the output register is free. Throughput: one
//   record beat per cycle while loading, none during the drain; the n stored records
//   drain one per cycle through cell 0 into the output register while it is free.
// Reset: count, overflow, state, registers and output valid clear; cells need
//   no clearing pass, only slots below the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_record_insertion_sorter_unit #(
	parameter int unsigned CAPACITY = srisu_pkg::CAPACITY_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [srisu_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [srisu_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [srisu_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                     pready,
	// record beats in
	input  wire logic                                rec_valid,
	output logic                                     rec_ready,
	input  wire srisu_pkg::in_beat_t                 rec_data,
	// result beats out
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output srisu_pkg::out_beat_t                     res_data
);

	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned LEVELS = $clog2(CAPACITY);

	// control and config registers
	srisu_pkg::state_t                 state_q, state_d;
	logic [CNT_W-1:0]                  count_q, count_d;
	logic [CNT_W-1:0]                  rem_q, rem_d;
	logic                              overflow_q, overflow_d;
	logic                              first_q, first_d;
	logic [1:0]                        key_select_q;
	logic                              descending_q;
	logic                              res_valid_q;
	srisu_pkg::out_beat_t              res_q;
	logic [srisu_pkg::KEY_W-1:0]       prev_key_q;

	// datapath
	srisu_pkg::rec_t                   new_rec;
	logic [srisu_pkg::KEY_W-1:0]       new_key;
	logic [srisu_pkg::KEY_W-1:0]       head_key;
	srisu_pkg::rec_t                   cell_rec [CAPACITY];
	wire  [CAPACITY-1:0]               le;
	logic [CAPACITY-1:0]               occ;
	logic [CAPACITY-1:0]               any_le;
	srisu_pkg::cell_link_t             link [CAPACITY];
	srisu_pkg::cell_ctl_t              ctl;

	logic                              cfg_wr;
	logic                              rec_acc;
	logic                              full;
	logic                              load_out;

	// ------------------------------------------------------------------------
	// configuration port, no wait states
	// ------------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (paddr[2])
			srisu_pkg::REG_KEY_SELECT: prdata = srisu_pkg::APB_DATA_W'(key_select_q);
			srisu_pkg::REG_DESCENDING: prdata = srisu_pkg::APB_DATA_W'(descending_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_select_q <= srisu_pkg::KEY_ID;
			descending_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				srisu_pkg::REG_KEY_SELECT: key_select_q <= pwdata[1:0];
				srisu_pkg::REG_DESCENDING: descending_q <= pwdata[0];
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// arriving record and its key, broadcast to every cell
	// ------------------------------------------------------------------------
	always_comb begin
		new_rec.student_id   = rec_data.student_id;
		new_rec.gender_code  = rec_data.gender_code;
		new_rec.score_first  = rec_data.score_first;
		new_rec.score_second = rec_data.score_second;
		new_rec.score_third  = rec_data.score_third;
		// arrival position is the fill count before this record
		new_rec.arrival      = srisu_pkg::ARRIVAL_W'(count_q);
		new_key              = srisu_pkg::sort_key(key_select_q, new_rec);
		head_key             = srisu_pkg::sort_key(key_select_q, cell_rec[0]);
	end

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign rec_ready = (state_q == srisu_pkg::ST_LOAD);
	assign rec_acc   = rec_valid & rec_ready;
	// output register is free or being emptied this cycle
	assign load_out  = ~res_valid_q | res_ready;

	assign ctl.ins   = rec_acc & ~full;
	assign ctl.drain = (state_q == srisu_pkg::ST_DRAIN) & load_out;

	// ------------------------------------------------------------------------
	// insertion point: a slot moves right only when no occupied slot at or
	// above it holds a key that is not greater than the new one, so the new
	// record lands just after the last such slot (stable, and still right
	// when the key changed mid-batch and the chain is not monotonic)
	// ------------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			occ[i] = (CNT_W'(i) < count_q);
		end
		// suffix or, log depth
		any_le = le;
		for (int lv = 0; lv < LEVELS; lv++) begin
			any_le = any_le | (any_le >> (1 << lv));
		end
		for (int i = 0; i < CAPACITY; i++) begin
			link[i].occ  = occ[i];
			link[i].pass = ~any_le[i];
			if (i == 0) begin
				link[i].left_occ  = 1'b1;
				link[i].left_pass = 1'b0;
			end else begin
				link[i].left_occ  = occ[i-1];
				link[i].left_pass = occ[i-1] & ~any_le[i-1];
			end
		end
	end

	// ------------------------------------------------------------------------
	// chain of cells, slot 0 holds the head of the sorted order
	// ------------------------------------------------------------------------
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		srisu_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.link       (link[g]),
			.key_select (key_select_q),
			.descending (descending_q),
			.new_rec    (new_rec),
			.new_key    (new_key),
			.left_rec   ((g == 0) ? new_rec : cell_rec[(g == 0) ? 0 : g-1]),
			.right_rec  ((g == CAPACITY-1) ? new_rec
				: cell_rec[(g == CAPACITY-1) ? g : g+1]),
			.rec_q      (cell_rec[g]),
			.le         (le[g])
		);
	end

	// ------------------------------------------------------------------------
	// sequencer: load records until the last one, then drain the chain
	// ------------------------------------------------------------------------
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rem_d      = rem_q;
		overflow_d = overflow_q;
		first_d    = first_q;
		unique case (state_q)
			srisu_pkg::ST_LOAD: begin
				if (rec_acc) begin
					if (full) begin
						overflow_d = 1'b1;
					end else begin
						count_d = count_q + CNT_W'(1);
					end
					if (rec_data.last_record) begin
						state_d = srisu_pkg::ST_DRAIN;
						rem_d   = full ? count_q : count_q + CNT_W'(1);
						first_d = 1'b1;
					end
				end
			end
			srisu_pkg::ST_DRAIN: begin
				if (load_out) begin
					rem_d   = rem_q - CNT_W'(1);
					first_d = 1'b0;
					if (rem_q == CNT_W'(1)) begin
						// batch done, empty the store
						state_d    = srisu_pkg::ST_LOAD;
						count_d    = '0;
						overflow_d = 1'b0;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srisu_pkg::ST_LOAD;
			count_q     <= '0;
			rem_q       <= '0;
			overflow_q  <= 1'b0;
			first_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			rem_q      <= rem_d;
			overflow_q <= overflow_d;
			first_q    <= first_d;
			if (ctl.drain) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// output payload, duplicate check against the previous head key
	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			res_q.out_id             <= cell_rec[0].student_id;
			res_q.out_gender         <= cell_rec[0].gender_code;
			res_q.out_score_first    <= cell_rec[0].score_first;
			res_q.out_score_second   <= cell_rec[0].score_second;
			res_q.out_score_third    <= cell_rec[0].score_third;
			res_q.arrival_index      <= cell_rec[0].arrival;
			res_q.same_key_as_before <= ~first_q & (head_key == prev_key_q);
			res_q.overflow           <= overflow_q;
			res_q.last_out           <= (rem_q == CNT_W'(1));
			prev_key_q               <= head_key;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srisu_pkg::ST_DRAIN) |-> (rem_q != '0) && (rem_q <= count_q))
		else $error("drain with nothing left");

	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_acc && rec_data.last_record) |=> (state_q == srisu_pkg::ST_DRAIN))
		else $error("last record did not start the drain");

	a_batch_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.drain && rem_q == CNT_W'(1)) |=>
			(count_q == '0) && !overflow_q && res_valid && res_data.last_out)
		else $error("batch end did not clear the store");

endmodule

`default_nettype wire

FILE: bench/tb_stable_record_insertion_sorter_unit.sv
// ----------------------------------------------------------------------------
// tb_stable_record_insertion_sorter_unit: self-checking bench for the sorter
// Record beats go in as batches. A behavioral copy of the stable sorter
// predicts every result beat, and a scoreboard compares the beats in order.
// Keys and direction are changed between batches and mid-batch. Full and
// overflowing batches are included, and both sides idle at random.
// ----------------------------------------------------------------------------

module tb_stable_record_insertion_sorter_unit;

	import srisu_pkg::*;

	localparam int unsigned STORE_DEPTH   = CAPACITY_DEF;
	localparam int unsigned RANDOM_ITEMS  = 420;
	localparam int unsigned SETTLE_CYCLES = 8;      // quiet spell before a register write
	localparam int unsigned DRAIN_CYCLES  = 20;
	localparam int unsigned LIMIT_CYCLES  = 300000;
	localparam int unsigned MAX_REPORTS   = 10;

	// score key codes, the package only names id and gender
	localparam logic [1:0] KEY_SCORE     = 2'd2;
	localparam logic [1:0] KEY_SCORE_ALT = 2'd3;    // falls back to the score key

	// one row of the directed table: a register write or a record beat
	typedef struct {
		bit          is_cfg;
		logic        reg_sel;
		logic [31:0] value;
		in_beat_t    beat;
		bit          typed;
		out_beat_t   typed_result;
	} stim_row_t;

	// ------------------------------------------------------------------------
	// clock, reset and block inputs, all known from time zero
	// ------------------------------------------------------------------------
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [APB_ADDR_W-1:0] paddr  = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic        pready;
	logic        rec_valid = 1'b0;
	logic        rec_ready;
	in_beat_t    rec_data  = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	out_beat_t   res_data;

	always #5 clk = ~clk;

	stable_record_insertion_sorter_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec_data  (rec_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// ------------------------------------------------------------------------
	// sorter model state: its own copy of the store and of both registers
	// ------------------------------------------------------------------------
	rec_t        sorted_store [STORE_DEPTH];
	int unsigned stored_count = 0;
	bit          dropped_any  = 1'b0;
	logic [1:0]  key_sel      = KEY_ID;
	logic        desc_order   = 1'b0;

	// result beats still owed by the block, oldest first
	out_beat_t   expected_results [$];

	// run statistics
	int unsigned mismatches       = 0;
	int unsigned results_checked  = 0;
	int unsigned beats_sent       = 0;
	int unsigned batches_closed   = 0;
	int unsigned overflow_batches = 0;
	int unsigned full_batches     = 0;
	int unsigned cfg_writes       = 0;
	int unsigned cycle_count      = 0;

	// idle-free stretches, one flag per side
	bit          src_calm  = 1'b0;
	bit          sink_calm = 1'b0;

	// ------------------------------------------------------------------------
	// key comparison, ascending sense: -1, 0 or 1
	// ------------------------------------------------------------------------
	function automatic int cmp_u(input logic [31:0] a, input logic [31:0] b);
		return (a < b) ? -1 : ((a > b) ? 1 : 0);
	endfunction

	function automatic int key_order(input rec_t a, input rec_t b);
		logic [8:0] tot_a;
		logic [8:0] tot_b;
		int         c;
		if (key_sel == KEY_ID)
			return cmp_u(a.student_id, b.student_id);
		if (key_sel == KEY_GENDER)
			return cmp_u(32'(a.gender_code), 32'(b.gender_code));
		// total score first, then the three scores in turn break ties
		tot_a = 9'(a.score_first) + 9'(a.score_second) + 9'(a.score_third);
		tot_b = 9'(b.score_first) + 9'(b.score_second) + 9'(b.score_third);
		c = cmp_u(32'(tot_a), 32'(tot_b));
		if (c == 0)
			c = cmp_u(32'(a.score_first), 32'(b.score_first));
		if (c == 0)
			c = cmp_u(32'(a.score_second), 32'(b.score_second));
		if (c == 0)
			c = cmp_u(32'(a.score_third), 32'(b.score_third));
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// insert one accepted record; on the batch end queue the sorted beats
	// a typed result, where given, stands in for the computed one
	// ------------------------------------------------------------------------
	task automatic predict_beat(input in_beat_t b, input bit use_typed,
		input out_beat_t typed_result);
		rec_t        nr;
		rec_t        prev;
		out_beat_t   o;
		int unsigned j;
		int          ord;
		nr.student_id   = b.student_id;
		nr.gender_code  = b.gender_code;
		nr.score_first  = b.score_first;
		nr.score_second = b.score_second;
		nr.score_third  = b.score_third;
		nr.arrival      = 6'(stored_count);
		if (stored_count < STORE_DEPTH) begin
			// stable: walk back only past records that order strictly after
			j = stored_count;
			while (j > 0) begin
				prev = sorted_store[j-1];
				ord  = desc_order ? -key_order(prev, nr) : key_order(prev, nr);
				if (ord <= 0)
					break;
				sorted_store[j] = prev;
				j--;
			end
			sorted_store[j] = nr;
			stored_count++;
		end else begin
			dropped_any = 1'b1;
		end
		if (b.last_record) begin
			for (int unsigned k = 0; k < stored_count; k++) begin
				o.out_id             = sorted_store[k].student_id;
				o.out_gender         = sorted_store[k].gender_code;
				o.out_score_first    = sorted_store[k].score_first;
				o.out_score_second   = sorted_store[k].score_second;
				o.out_score_third    = sorted_store[k].score_third;
				o.arrival_index      = sorted_store[k].arrival;
				// duplicate flag uses the key in force at output time
				o.same_key_as_before = (k > 0) &&
					(key_order(sorted_store[k-1], sorted_store[k]) == 0);
				o.overflow           = dropped_any;
				o.last_out           = (k + 1 == stored_count);
				expected_results.push_back(use_typed ? typed_result : o);
			end
			batches_closed++;
			if (dropped_any)
				overflow_batches++;
			if (stored_count == STORE_DEPTH)
				full_batches++;
			stored_count = 0;
			dropped_any  = 1'b0;
		end
	endtask

	function automatic string beat_text(input out_beat_t r);
		return $sformatf("id=%h g=%h sc=%0d/%0d/%0d arr=%0d same=%b ovf=%b last=%b",
			r.out_id, r.out_gender, r.out_score_first, r.out_score_second,
			r.out_score_third, r.arrival_index, r.same_key_as_before, r.overflow,
			r.last_out);
	endfunction

	// ------------------------------------------------------------------------
	// scoreboard: compare one accepted result beat with the oldest expectation
	// ------------------------------------------------------------------------
	task automatic check_result(input out_beat_t got);
		out_beat_t want;
		bit        bad;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("[%0d] result beat with nothing expected: %s", cycle_count,
					beat_text(got));
			return;
		end
		want = expected_results.pop_front();
		results_checked++;
		bad = (got.out_id !== want.out_id)
			|| (got.out_gender !== want.out_gender)
			|| (got.out_score_first !== want.out_score_first)
			|| (got.out_score_second !== want.out_score_second)
			|| (got.out_score_third !== want.out_score_third)
			|| (got.arrival_index !== want.arrival_index)
			|| (got.same_key_as_before !== want.same_key_as_before)
			|| (got.overflow !== want.overflow)
			|| (got.last_out !== want.last_out);
		if (bad) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("[%0d] result %0d expected %s", cycle_count, results_checked,
					beat_text(want));
				$display("[%0d] result %0d actual   %s", cycle_count, results_checked,
					beat_text(got));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// record source: entered and left at a falling edge
	// ------------------------------------------------------------------------
	task automatic send_beat(input in_beat_t b, input bit use_typed,
		input out_beat_t typed_result);
		int unsigned gap;
		gap = src_calm ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			rec_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rec_valid <= 1'b1;
		rec_data  <= b;
		@(posedge clk);
		while (!rec_ready)
			@(posedge clk);
		beats_sent++;
		predict_beat(b, use_typed, typed_result);
		@(negedge clk);
	endtask

	// register write, only once the block has gone quiet
	task automatic write_reg(input logic reg_sel, input logic [31:0] value);
		rec_valid <= 1'b0;
		// all owed beats out, then a short quiet spell
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		// setup phase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		// access phase, the write lands on the edge with pready high
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (reg_sel == REG_KEY_SELECT)
			key_sel = value[1:0];
		else
			desc_order = value[0];
		cfg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// table row builders
	function automatic stim_row_t cfg_row(input logic reg_sel, input logic [31:0] value);
		stim_row_t r;
		r         = '{default: '0};
		r.is_cfg  = 1'b1;
		r.reg_sel = reg_sel;
		r.value   = value;
		return r;
	endfunction

	function automatic stim_row_t rec_row(input logic [31:0] id, input logic [7:0] g,
		input logic [6:0] s1, input logic [6:0] s2, input logic [6:0] s3,
		input logic last);
		stim_row_t r;
		r      = '{default: '0};
		r.beat = '{student_id: id, gender_code: g, score_first: s1,
			score_second: s2, score_third: s3, last_record: last};
		return r;
	endfunction

	// a record that is a batch on its own comes back unchanged, first and last
	function automatic stim_row_t lone_row(input logic [31:0] id, input logic [7:0] g,
		input logic [6:0] s1, input logic [6:0] s2, input logic [6:0] s3);
		stim_row_t r;
		r              = rec_row(id, g, s1, s2, s3, 1'b1);
		r.typed        = 1'b1;
		r.typed_result = '{out_id: id, out_gender: g, out_score_first: s1,
			out_score_second: s2, out_score_third: s3, arrival_index: 6'd0,
			same_key_as_before: 1'b0, overflow: 1'b0, last_out: 1'b1};
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("[%0d] watchdog expired, %0d result beats still owed", cycle_count,
				expected_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// result sink: random stalls, with idle-free stretches now and then
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int unsigned stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				sink_calm = !sink_calm;
			stall = sink_calm ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid)
				@(posedge clk);
			check_result(res_data);
			@(negedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// main sequence: reset, directed table, random batches, wind-down
	// ------------------------------------------------------------------------
	initial begin : stimulus
		stim_row_t   directed [$];
		in_beat_t    b;
		out_beat_t   none;
		int unsigned random_beats;
		int unsigned batch_len;
		int unsigned id_mode;
		int unsigned g_mode;
		int unsigned sc_mode;
		logic [6:0]  sc [3];
		none         = '0;
		random_beats = 0;

		// lone records: all-zero, all-ones with top scores, scores past one hundred
		directed.push_back(lone_row(32'h0000_0000, 8'h00, 7'd0, 7'd0, 7'd0));
		directed.push_back(lone_row(32'hFFFF_FFFF, 8'hFF, 7'd100, 7'd100, 7'd100));
		directed.push_back(lone_row(32'h5A5A_A5A5, 8'hA5, 7'd127, 7'd127, 7'd127));
		// reset setting, id ascending: equal ids must keep arrival order
		directed.push_back(rec_row(32'd7, 8'h4D, 7'd10, 7'd20, 7'd30, 1'b0));
		directed.push_back(rec_row(32'd3, 8'h46, 7'd40, 7'd50, 7'd60, 1'b0));
		directed.push_back(rec_row(32'd7, 8'h46, 7'd70, 7'd80, 7'd90, 1'b0));
		directed.push_back(rec_row(32'd3, 8'h4D, 7'd1, 7'd2, 7'd3, 1'b0));
		directed.push_back(rec_row(32'd9, 8'h4D, 7'd4, 7'd5, 7'd6, 1'b1));
		// gender key, descending, byte extremes
		directed.push_back(cfg_row(REG_KEY_SELECT, 32'(KEY_GENDER)));
		directed.push_back(cfg_row(REG_DESCENDING, 32'd1));
		directed.push_back(rec_row(32'd100, 8'h4D, 7'd11, 7'd12, 7'd13, 1'b0));
		directed.push_back(rec_row(32'd101, 8'h46, 7'd14, 7'd15, 7'd16, 1'b0));
		directed.push_back(rec_row(32'd102, 8'h4D, 7'd17, 7'd18, 7'd19, 1'b0));
		directed.push_back(rec_row(32'd103, 8'hFF, 7'd20, 7'd21, 7'd22, 1'b0));
		directed.push_back(rec_row(32'd104, 8'h00, 7'd23, 7'd24, 7'd25, 1'b1));
		// score key ascending: equal totals, ties settled by the single scores
		directed.push_back(cfg_row(REG_KEY_SELECT, 32'(KEY_SCORE)));
		directed.push_back(cfg_row(REG_DESCENDING, 32'd0));
		directed.push_back(rec_row(32'd200, 8'h4D, 7'd10, 7'd20, 7'd30, 1'b0));
		directed.push_back(rec_row(32'd201, 8'h46, 7'd30, 7'd20, 7'd10, 1'b0));
		directed.push_back(rec_row(32'd202, 8'h4D, 7'd10, 7'd20, 7'd30, 1'b0));
		directed.push_back(rec_row(32'd203, 8'h46, 7'd20, 7'd20, 7'd20, 1'b1));
		// spare key code behaves as the score key, descending
		directed.push_back(cfg_row(REG_KEY_SELECT, 32'(KEY_SCORE_ALT)));
		directed.push_back(cfg_row(REG_DESCENDING, 32'd1));
		directed.push_back(rec_row(32'd300, 8'h4D, 7'd100, 7'd100, 7'd100, 1'b0));
		directed.push_back(rec_row(32'd301, 8'h46, 7'd0, 7'd0, 7'd0, 1'b0));
		directed.push_back(rec_row(32'd302, 8'h4D, 7'd50, 7'd50, 7'd50, 1'b1));
		directed.push_back(cfg_row(REG_KEY_SELECT, 32'(KEY_ID)));
		directed.push_back(cfg_row(REG_DESCENDING, 32'd0));

		// reset held low from the start, then released once
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg)
				write_reg(directed[i].reg_sel, directed[i].value);
			else
				send_beat(directed[i].beat, directed[i].typed, directed[i].typed_result);
		end

		// random batches; config between batches also makes the source wait out
		// every owed beat
		while (random_beats < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_KEY_SELECT, ($urandom & ~32'h3) | $urandom_range(0, 3));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_DESCENDING, ($urandom & ~32'h1) | $urandom_range(0, 1));
			src_calm = ($urandom_range(0, 4) == 0);
			// mostly short batches, some exactly full, some past capacity
			case ($urandom_range(0, 11))
				0:       batch_len = STORE_DEPTH;
				1:       batch_len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
				default: batch_len = $urandom_range(1, 12);
			endcase
			// narrow value sets give equal keys, wide ones reach every bit
			id_mode = $urandom_range(0, 2);
			g_mode  = $urandom_range(0, 1);
			sc_mode = $urandom_range(0, 3);
			for (int unsigned n = 0; n < batch_len; n++) begin
				case (id_mode)
					0:       b.student_id = $urandom;
					1:       b.student_id = $urandom_range(0, 7);
					default: b.student_id = 32'hFFFF_FFF8 | $urandom_range(0, 7);
				endcase
				if (g_mode == 0)
					b.gender_code = 8'($urandom_range(0, 255));
				else
					b.gender_code = $urandom_range(0, 1) ? 8'h4D : 8'h46;
				for (int s = 0; s < 3; s++) begin
					case (sc_mode)
						0:       sc[s] = 7'($urandom_range(0, 127));
						1:       sc[s] = 7'(50 * $urandom_range(0, 2));
						default: sc[s] = 7'($urandom_range(0, 100));
					endcase
				end
				b.score_first  = sc[0];
				b.score_second = sc[1];
				b.score_third  = sc[2];
				b.last_record  = (n + 1 == batch_len);
				// now and then change a register while records sit in the store
				if (!b.last_record && $urandom_range(0, 39) == 0)
					write_reg($urandom_range(0, 1) ? REG_KEY_SELECT : REG_DESCENDING,
						$urandom_range(0, 3));
				send_beat(b, 1'b0, none);
				random_beats++;
			end
		end

		// wind-down: everything owed must arrive, then a short quiet spell
		rec_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			mismatches++;
			$display("%0d result beats never arrived", expected_results.size());
		end

		$display("covered %0d record beats in %0d batches (%0d full, %0d overflowing)",
			beats_sent, batches_closed, full_batches, overflow_batches);
		$display("checked %0d result beats across %0d register writes, %0d mismatches",
			results_checked, cfg_writes, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: stable_record_insertion_sorter_unit.f
sv/srisu_pkg.sv
sv/srisu_cell.sv
sv/stable_record_insertion_sorter_unit.sv
bench/tb_stable_record_insertion_sorter_unit.sv
